/* design/srdp_pkg.sv */
// Shared types and constants for the sparse row store dot product block.
package srdp_pkg;

   localparam int MAX_ROWS      = 1024;
   localparam int MAX_NONZEROS  = 4096;
   localparam int COLUMN_BITS   = 16;
   localparam int ROW_ADDR_BITS = $clog2(MAX_ROWS);
   localparam int ROWS_BITS     = ROW_ADDR_BITS + 1;
   localparam int NNZ_ADDR_BITS = $clog2(MAX_NONZEROS);
   localparam int PTR_BITS      = NNZ_ADDR_BITS + 1;
   localparam int VALUE_BITS    = 32;
   localparam int ACC_BITS      = 64;
   localparam int WIDTH_BITS    = 16;
   localparam int REQ_DATA_BITS = 72;
   localparam int RSP_USER_BITS = 3;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_NOT_LOADED = 2'd1,
      STATUS_OVERFLOW   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROWS,
      ST_FETCH,
      ST_COMP,
      ST_ACC,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_en;
      logic query_start;
      logic ptr_load;
      logic fetch;
      logic step;
      logic acc_en;
      logic out_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic rows_ok;
      logic walk_done;
      logic limit_hit;
      logic match;
      logic rsp_free;
   } stat_type;

endpackage

/* design/srdp_ctrl.sv */
// Controller state machine that sequences loads and the merge walk of a query.
module srdp_ctrl
   import srdp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   input  logic     req_action,
   output logic     req_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_action) begin
                  cmd.query_start = 1'b1;
                  state_in = stat.rows_ok ? ST_ROWS : ST_DONE;
               end else begin
                  cmd.load_en = 1'b1;
               end
            end
         end
         ST_ROWS: begin
            cmd.ptr_load = 1'b1;
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            if (stat.walk_done) begin
               state_in = ST_DONE;
            end else begin
               cmd.fetch = 1'b1;
               state_in = ST_COMP;
            end
         end
         ST_COMP: begin
            if (stat.limit_hit) begin
               state_in = ST_DONE;
            end else begin
               cmd.step = 1'b1;
               state_in = stat.match ? ST_ACC : ST_FETCH;
            end
         end
         ST_ACC: begin
            cmd.acc_en = 1'b1;
            state_in = ST_FETCH;
         end
         ST_DONE: begin
            if (stat.rsp_free) begin
               cmd.out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* design/srdp_path.sv */
// Datapath: element store, row tables, merge pointers, multiplier and saturating sum.
module srdp_path
   import srdp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [WIDTH_BITS-1:0]    csr_wr_data,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   input  cmd_type                  cmd,
   output stat_type                 stat,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [ACC_BITS-1:0]      rsp_tdata,
   output logic [RSP_USER_BITS-1:0] rsp_tuser
);

   localparam int ENTRY_BITS = COLUMN_BITS + VALUE_BITS;
   localparam int ROWENT_BITS = 2 * PTR_BITS;

   // Element store and row tables.
   logic [ENTRY_BITS-1:0]  elem_mem [MAX_NONZEROS];
   logic [ROWENT_BITS-1:0] row_mem  [MAX_ROWS];

   logic [ENTRY_BITS-1:0]  elem_a_ff, elem_b_ff;
   logic [ROWENT_BITS-1:0] row_a_ff, row_b_ff;

   // Load state.
   logic [WIDTH_BITS-1:0]  width_ff;
   logic [PTR_BITS-1:0]    fill_ff, fill_in;
   logic [ROWS_BITS-1:0]   rows_ff, rows_in;
   logic [COLUMN_BITS-1:0] col_ff, col_in;
   logic [PTR_BITS-1:0]    cur_start_ff, cur_start_in;
   logic [PTR_BITS-1:0]    cur_count_ff, cur_count_in;
   logic                   ovf_ff, ovf_in;

   // Query state.
   logic [PTR_BITS-1:0]    pa_ff, pb_ff, na_ff, nb_ff;
   logic [COLUMN_BITS-1:0] limit_ff;
   logic signed [ACC_BITS-1:0] prod_ff, acc_ff, sum;
   logic                   clip_ff;
   status_type             status_ff;
   logic                   rsp_valid_ff;
   logic [ACC_BITS-1:0]    rsp_data_ff;
   logic [RSP_USER_BITS-1:0] rsp_user_ff;

   // Request fields.
   logic [VALUE_BITS-1:0]    req_value;
   logic [ROW_ADDR_BITS-1:0] req_row_a, req_row_b;
   logic [COLUMN_BITS-1:0]   req_limit;

   assign req_value = req_tdata[31:0];
   assign req_row_a = req_tdata[41:32];
   assign req_row_b = req_tdata[51:42];
   assign req_limit = req_tdata[67:52];

   // Load decisions for one dense element.
   logic                  ld_active, ld_nonzero, ld_keep, ld_row_end;
   logic [PTR_BITS-1:0]   ld_start, ld_count;
   logic [WIDTH_BITS:0]   ld_eff_width, ld_next_col;

   always_comb begin
      ld_active    = cmd.load_en && !rows_ff[ROWS_BITS-1];
      ld_nonzero   = req_value != '0;
      ld_keep      = ld_active && ld_nonzero && !fill_ff[PTR_BITS-1];
      ld_start     = (col_ff == '0) ? fill_ff : cur_start_ff;
      ld_count     = ((col_ff == '0) ? '0 : cur_count_ff) + PTR_BITS'(ld_keep);
      ld_eff_width = (width_ff == '0) ? (WIDTH_BITS+1)'(1) : {1'b0, width_ff};
      ld_next_col  = {1'b0, col_ff} + (WIDTH_BITS+1)'(1);
      ld_row_end   = ld_next_col >= ld_eff_width;

      fill_in      = fill_ff + PTR_BITS'(ld_keep);
      rows_in      = rows_ff;
      col_in       = col_ff;
      cur_start_in = cur_start_ff;
      cur_count_in = cur_count_ff;
      ovf_in       = ovf_ff;
      if (cmd.load_en) begin
         if (!ld_active || (ld_nonzero && !ld_keep)) begin
            ovf_in = 1'b1;
         end
         if (ld_active) begin
            cur_start_in = ld_start;
            cur_count_in = ld_count;
            if (ld_row_end) begin
               col_in  = '0;
               rows_in = rows_ff + ROWS_BITS'(1);
            end else begin
               col_in  = ld_next_col[COLUMN_BITS-1:0];
            end
         end
      end
   end

   // Load control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_BITS'(1);
         fill_ff   <= '0;
         rows_ff   <= '0;
         col_ff    <= '0;
         ovf_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            width_ff <= csr_wr_data;
         end
         fill_ff <= fill_in;
         rows_ff <= rows_in;
         col_ff  <= col_in;
         ovf_ff  <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_start_ff <= cur_start_in;
      cur_count_ff <= cur_count_in;
   end

   // Element store: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (ld_keep) begin
         elem_mem[fill_ff[NNZ_ADDR_BITS-1:0]] <= {col_ff, req_value};
      end
      if (cmd.fetch) begin
         elem_a_ff <= elem_mem[pa_ff[NNZ_ADDR_BITS-1:0]];
         elem_b_ff <= elem_mem[pb_ff[NNZ_ADDR_BITS-1:0]];
      end
   end

   // Row table: written when a row completes, read at both query rows.
   always_ff @(posedge clock) begin
      if (ld_active && ld_row_end) begin
         row_mem[rows_ff[ROW_ADDR_BITS-1:0]] <= {ld_start, ld_count};
      end
      if (cmd.query_start) begin
         row_a_ff <= row_mem[req_row_a];
         row_b_ff <= row_mem[req_row_b];
      end
   end

   // Merge walk compare.
   logic [COLUMN_BITS-1:0] col_a, col_b;
   logic [VALUE_BITS-1:0]  val_a, val_b;

   assign col_a = elem_a_ff[ENTRY_BITS-1:VALUE_BITS];
   assign col_b = elem_b_ff[ENTRY_BITS-1:VALUE_BITS];
   assign val_a = elem_a_ff[VALUE_BITS-1:0];
   assign val_b = elem_b_ff[VALUE_BITS-1:0];

   always_comb begin
      stat.rows_ok   = ({1'b0, req_row_a} < rows_ff) && ({1'b0, req_row_b} < rows_ff);
      stat.walk_done = (na_ff == '0) || (nb_ff == '0) ||
                       pa_ff[PTR_BITS-1] || pb_ff[PTR_BITS-1];
      stat.limit_hit = col_a >= limit_ff;
      stat.match     = col_a == col_b;
      stat.rsp_free  = !rsp_valid_ff || rsp_tready;
   end

   // Saturating add of the registered product.
   logic sum_ovf;
   always_comb begin
      sum     = acc_ff + prod_ff;
      sum_ovf = (acc_ff[ACC_BITS-1] == prod_ff[ACC_BITS-1]) &&
                (sum[ACC_BITS-1] != acc_ff[ACC_BITS-1]);
   end

   // Query registers.
   always_ff @(posedge clock) begin
      if (cmd.query_start) begin
         limit_ff  <= req_limit;
         acc_ff    <= '0;
         clip_ff   <= 1'b0;
         if (!stat.rows_ok) begin
            status_ff <= STATUS_NOT_LOADED;
         end else if (ovf_ff) begin
            status_ff <= STATUS_OVERFLOW;
         end else begin
            status_ff <= STATUS_OK;
         end
      end
      if (cmd.ptr_load) begin
         pa_ff <= row_a_ff[ROWENT_BITS-1:PTR_BITS];
         na_ff <= row_a_ff[PTR_BITS-1:0];
         pb_ff <= row_b_ff[ROWENT_BITS-1:PTR_BITS];
         nb_ff <= row_b_ff[PTR_BITS-1:0];
      end
      if (cmd.step) begin
         if (stat.match) begin
            prod_ff <= $signed(val_a) * $signed(val_b);
            pa_ff <= pa_ff + PTR_BITS'(1);
            na_ff <= na_ff - PTR_BITS'(1);
            pb_ff <= pb_ff + PTR_BITS'(1);
            nb_ff <= nb_ff - PTR_BITS'(1);
         end else if (col_a < col_b) begin
            pa_ff <= pa_ff + PTR_BITS'(1);
            na_ff <= na_ff - PTR_BITS'(1);
         end else begin
            pb_ff <= pb_ff + PTR_BITS'(1);
            nb_ff <= nb_ff - PTR_BITS'(1);
         end
      end
      if (cmd.acc_en) begin
         if (sum_ovf) begin
            clip_ff <= 1'b1;
            acc_ff  <= prod_ff[ACC_BITS-1] ? {1'b1, {(ACC_BITS-1){1'b0}}}
                                           : {1'b0, {(ACC_BITS-1){1'b1}}};
         end else begin
            acc_ff <= sum;
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= acc_ff;
         rsp_user_ff <= {clip_ff, status_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

/* design/sparse_row_store_dot_product.sv */
// Top level of the sparse row store dot product block.
// A load word is taken every cycle while idle and produces no response. A query
// reads the row entries, loads the merge pointers and walks the rows; each matching column
// is multiplied, then added with saturation. The walk ends when a row runs out or the
// column limit is reached; an unloaded-row query skips the walk. The next word is taken
// the cycle after the response is loaded. Synchronous active-high reset clears
// the fill pointer, row count, column counter, overflow flag and row width (to 1).
module sparse_row_store_dot_product
   import srdp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [WIDTH_BITS-1:0]    csr_wr_data,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // value[31:0], row_a[41:32], row_b[51:42], limit_col[67:52], zeros above
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // action[0]
   input  logic                     req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // dot_result[63:0]
   output logic [ACC_BITS-1:0]      rsp_tdata,
   // status[1:0], saturated[2]
   output logic [RSP_USER_BITS-1:0] rsp_tuser
);

   cmd_type  cmd;
   stat_type stat;

   srdp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_action (req_tuser),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   srdp_path u_path (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tdata   (req_tdata),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

/* design/srdp_checker.sv */
// Port-level checker for the sparse row store dot product block, with its bind.
module srdp_checker
   import srdp_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tvalid,
   input logic                     req_tready,
   input logic                     req_tuser,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [ACC_BITS-1:0]      rsp_tdata,
   input logic [RSP_USER_BITS-1:0] rsp_tuser
);

   // A stalled response word holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // An unloaded-row response carries a zero sum and no clipping.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] == STATUS_NOT_LOADED |-> rsp_tdata == '0 && !rsp_tuser[2])
      else $error("unloaded-row response not clean");

   // Status never takes the unused code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser[1:0] != 2'd3)
      else $error("bad status code");

   // A load word never yields a response on the next cycle from idle.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser && !rsp_tvalid |=> !rsp_tvalid)
      else $error("response after a load");

endmodule

bind sparse_row_store_dot_product srdp_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

/* test/testbench.sv */
// Self-checking testbench for the sparse row store dot product block.
`timescale 1ns / 1ps

module testbench;
   import srdp_pkg::*;

   localparam int HALF_PERIOD = 2;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int SETTLE_CYCLES = 12;
   localparam int RANDOM_WORDS = 900;
   localparam int WIDE_COLS = 48;
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_QUERY = 1'b1;
   localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

   // Expected response of one query.
   typedef struct {
      logic signed [ACC_BITS-1:0] dot;
      status_type                 status;
      logic                       saturated;
   } dot_response;

   logic                     clock;
   logic                     reset;
   logic                     csr_wr_en;
   logic [WIDTH_BITS-1:0]    csr_wr_data;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata;
   logic                     req_tuser;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [ACC_BITS-1:0]      rsp_tdata;
   logic [RSP_USER_BITS-1:0] rsp_tuser;

   // Shadow copy of the row store.
   logic [COLUMN_BITS-1:0] shadow_col [MAX_NONZEROS];
   logic [VALUE_BITS-1:0]  shadow_val [MAX_NONZEROS];
   int unsigned            row_base [MAX_ROWS];
   int unsigned            row_len [MAX_ROWS];
   int unsigned            fill_ptr;
   int unsigned            rows_done;
   int unsigned            col_pos;
   logic                   store_overflowed;
   logic [WIDTH_BITS-1:0]  width_reg;

   dot_response pending_dots[$];
   int unsigned mismatches;
   int unsigned cycles;
   logic        idling_on;

   sparse_row_store_dot_product u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   always begin
      clock = 1'b1;
      #HALF_PERIOD;
      clock = 1'b0;
      #HALF_PERIOD;
   end

   // Appends one dense element to the shadow store.
   function automatic void store_element(logic [VALUE_BITS-1:0] v);
      int unsigned w;
      w = (width_reg == 0) ? 1 : width_reg;
      if (rows_done >= MAX_ROWS) begin
         store_overflowed = 1'b1;
         return;
      end
      if (col_pos == 0) begin
         row_base[rows_done] = fill_ptr;
         row_len[rows_done] = 0;
      end
      if (v != 0) begin
         if (col_pos >= (1 << COLUMN_BITS) || fill_ptr >= MAX_NONZEROS) begin
            store_overflowed = 1'b1;
         end else begin
            shadow_col[fill_ptr] = col_pos[COLUMN_BITS-1:0];
            shadow_val[fill_ptr] = v;
            fill_ptr++;
            row_len[rows_done]++;
         end
      end
      if (col_pos + 1 >= w) begin
         col_pos = 0;
         rows_done++;
      end else begin
         col_pos = (col_pos + 1) & 16'hFFFF;
      end
   endfunction

   // Merges two stored rows and forms the saturating sum of products.
   function automatic dot_response row_dot(int unsigned ra, int unsigned rb,
                                           int unsigned lim);
      dot_response r;
      int unsigned pa, pb, na, nb;
      logic signed [ACC_BITS:0] sum;
      logic signed [ACC_BITS-1:0] prod;
      r.dot = '0;
      r.saturated = 1'b0;
      if (ra >= rows_done || rb >= rows_done) begin
         r.status = STATUS_NOT_LOADED;
         return r;
      end
      pa = row_base[ra];
      na = row_len[ra];
      pb = row_base[rb];
      nb = row_len[rb];
      while (na != 0 && nb != 0 && pa < MAX_NONZEROS && pb < MAX_NONZEROS) begin
         if (shadow_col[pa] >= lim) break;
         if (shadow_col[pa] == shadow_col[pb]) begin
            prod = $signed(shadow_val[pa]) * $signed(shadow_val[pb]);
            sum = r.dot + prod;
            if (sum > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
               r.dot = 64'sh7FFF_FFFF_FFFF_FFFF;
               r.saturated = 1'b1;
            end else if (sum < -65'sh0_8000_0000_0000_0000) begin
               r.dot = 64'sh8000_0000_0000_0000;
               r.saturated = 1'b1;
            end else begin
               r.dot = sum[ACC_BITS-1:0];
            end
            pa++; na--; pb++; nb--;
         end else if (shadow_col[pa] < shadow_col[pb]) begin
            pa++; na--;
         end else begin
            pb++; nb--;
         end
      end
      r.status = store_overflowed ? STATUS_OVERFLOW : STATUS_OK;
      return r;
   endfunction

   // Sends one word and updates the shadow model once it is taken.
   task automatic send_word(logic act, logic [31:0] v, int unsigned ra, int unsigned rb,
                            int unsigned lim);
      @(negedge clock);
      while (idling_on && $urandom_range(99) < 34) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {4'b0, lim[15:0], rb[9:0], ra[9:0], v};
      do @(posedge clock); while (!req_tready);
      if (act == ACT_QUERY) pending_dots.push_back(row_dot(ra, rb, lim));
      else store_element(v);
   endtask

   // Random dense value, zero about half the time.
   function automatic logic [31:0] pick_value();
      case ($urandom_range(9))
         0, 1, 2, 3, 4: return '0;
         5: return VAL_MIN;
         6: return VAL_MAX;
         default: return $urandom;
      endcase
   endfunction

   // Query mostly over loaded rows, sometimes over any row index.
   task automatic send_query(int unsigned row_cols);
      int unsigned ra, rb, lim;
      ra = (rows_done > 0 && $urandom_range(9) > 0) ?
           $urandom_range(rows_done - 1) : $urandom_range(MAX_ROWS - 1);
      rb = (rows_done > 0 && $urandom_range(9) > 0) ?
           $urandom_range(rows_done - 1) : $urandom_range(MAX_ROWS - 1);
      lim = ($urandom_range(9) < 7) ? $urandom_range(row_cols + 2) : $urandom_range(16'hFFFF);
      send_word(ACT_QUERY, '0, ra, rb, lim);
   endtask

   // Lets the block go idle, then writes the row width.
   task automatic set_row_width(int unsigned w);
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (pending_dots.size() == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= w[15:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
      width_reg = w[15:0];
   endtask

   // Result side stalls at random.
   always @(negedge clock) begin
      rsp_tready <= !(idling_on && $urandom_range(99) < 34);
   end

   // Compare each response word with the oldest expected one.
   always @(posedge clock) begin
      dot_response e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_dots.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response word %h", rsp_tdata);
         end else begin
            e = pending_dots.pop_front();
            if (rsp_tdata !== e.dot || rsp_tuser[1:0] !== e.status ||
                rsp_tuser[2] !== e.saturated) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected dot %h status %0d sat %0d, got %h %0d %0d",
                           e.dot, e.status, e.saturated, rsp_tdata, rsp_tuser[1:0],
                           rsp_tuser[2]);
            end
         end
      end
   end

   // Cycle limit.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   // Width one by default, zero width, extreme values and unloaded rows.
   task automatic test_unit_rows();
      send_word(ACT_QUERY, '0, 0, 0, 16'hFFFF);
      send_word(ACT_LOAD, VAL_MIN, 0, 0, 0);
      send_word(ACT_LOAD, VAL_MAX, 0, 0, 0);
      send_word(ACT_LOAD, '0, 0, 0, 0);
      send_word(ACT_LOAD, 32'hFFFF_FFFF, 0, 0, 0);
      send_word(ACT_QUERY, '0, 0, 0, 16'hFFFF);
      send_word(ACT_QUERY, '0, 0, 1, 16'hFFFF);
      send_word(ACT_QUERY, '0, 2, 2, 0);
      send_word(ACT_QUERY, '0, 1023, 0, 1);
      send_word(ACT_QUERY, '0, 0, 1023, 1);
      set_row_width(0);
      send_word(ACT_LOAD, 32'h0001_0000, 0, 0, 0);
      send_word(ACT_QUERY, '0, 4, 4, 1);
      send_word(ACT_QUERY, '0, 4, 0, 1);
   endtask

   // Full-scale rows that drive the sum into both clipping limits.
   task automatic test_saturation();
      set_row_width(8);
      repeat (8) send_word(ACT_LOAD, VAL_MIN, 0, 0, 0);
      repeat (8) send_word(ACT_LOAD, VAL_MAX, 0, 0, 0);
      send_word(ACT_QUERY, '0, 5, 5, 8);
      send_word(ACT_QUERY, '0, 5, 6, 8);
      send_word(ACT_QUERY, '0, 6, 6, 3);
      send_word(ACT_QUERY, '0, 6, 5, 0);
   endtask

   // Row width shrinks while a row is partly loaded.
   task automatic test_width_change();
      set_row_width(10);
      repeat (5) send_word(ACT_LOAD, $urandom, 0, 0, 0);
      set_row_width(3);
      repeat (4) send_word(ACT_LOAD, $urandom, 0, 0, 0);
      send_word(ACT_QUERY, '0, 7, 8, 16'hFFFF);
      send_word(ACT_QUERY, '0, 8, 7, 16'hFFFF);
   endtask

   // Mixed loads and queries over changing row widths.
   task automatic test_random_mix();
      int unsigned w;
      w = width_reg;
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         idling_on = !(i >= 300 && i < 600);
         if (i % 300 == 299) begin
            w = $urandom_range(1, 24);
            set_row_width(w);
         end
         if ($urandom_range(9) < 3) send_query(w);
         else send_word(ACT_LOAD, pick_value(), 0, 0, 0);
      end
      idling_on = 1'b1;
   endtask

   // A row opened under the widest width and closed early by a width of one.
   task automatic test_widest_row();
      int unsigned r;
      set_row_width(16'hFFFF);
      r = rows_done;
      for (int c = 0; c < WIDE_COLS; c++)
         send_word(ACT_LOAD, ($urandom_range(3) == 0 || c == WIDE_COLS - 1) ? $urandom : 0,
                   0, 0, 0);
      set_row_width(1);
      send_word(ACT_LOAD, $urandom, 0, 0, 0);
      send_word(ACT_QUERY, '0, r, r, 16'hFFFF);
      send_word(ACT_QUERY, '0, r, r, WIDE_COLS / 2);
      send_word(ACT_QUERY, '0, r, 0, 16'hFFFF);
   endtask

   // Single-column rows run past the row count, which marks the store overflowed.
   task automatic test_store_full();
      set_row_width(1);
      while (rows_done < MAX_ROWS || $urandom_range(39) > 0) begin
         if ($urandom_range(29) == 0) send_query(16);
         else send_word(ACT_LOAD, ($urandom_range(7) == 0) ? 0 : $urandom, 0, 0, 0);
      end
      repeat (10) send_query(16);
      send_word(ACT_QUERY, '0, 1023, 0, 16'hFFFF);
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;
      mismatches = 0;
      cycles = 0;
      idling_on = 1'b1;
      fill_ptr = 0;
      rows_done = 0;
      col_pos = 0;
      store_overflowed = 1'b0;
      width_reg = 1;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      test_unit_rows();
      test_saturation();
      test_width_change();
      test_random_mix();
      test_widest_row();
      test_store_full();

      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (pending_dots.size() == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0 && pending_dots.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

/* filelist.f */
design/srdp_pkg.sv
design/srdp_ctrl.sv
design/srdp_path.sv
design/sparse_row_store_dot_product.sv
design/srdp_checker.sv
test/testbench.sv
